### rtl/sclfp_pkg.sv
package sclfp_pkg;

  // Frame marker and function codes
  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] FN_READ   = 8'hF1;
  localparam logic [7:0] FN_WRITE  = 8'hF2;

  // Header bytes before the payload: two sync, function, length
  localparam int HEAD_LEN = 4;

  // Default upper bound on the length byte
  localparam int MAX_PAYLOAD_DEF = 10;

  // Decoded frame as handed to the result channel
  typedef struct packed {
    logic        is_write;
    logic [7:0]  group;
    logic [7:0]  offset;
    logic [15:0] value;
    logic [3:0]  payload_len;
    logic [15:0] frame_count;
  } result_t;

endpackage

### rtl/sclfp_in_if.sv
interface sclfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/sclfp_out_if.sv
interface sclfp_out_if;
  logic        valid;
  logic        ready;
  logic        is_write;
  logic [7:0]  group;
  logic [7:0]  offset;
  logic [15:0] value;
  logic [3:0]  payload_len;
  logic [15:0] frame_count;

  modport source (output valid, output is_write, output group, output offset,
                  output value, output payload_len, output frame_count, input ready);
  modport sink (input valid, input is_write, input group, input offset,
                input value, input payload_len, input frame_count, output ready);
endinterface

### rtl/sclfp_parse.sv
module sclfp_parse #(
  parameter int MAX_PAYLOAD = sclfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                checksum_check,
  output logic                emit,
  output sclfp_pkg::result_t  res
);

  localparam int PosW = $clog2(MAX_PAYLOAD + sclfp_pkg::HEAD_LEN + 1);
  localparam int LenW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [PosW-1:0] PosHead = PosW'(sclfp_pkg::HEAD_LEN);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            wr_r, wr_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      grp_r, grp_nxt;
  logic [7:0]      ofs_r, ofs_nxt;
  logic [15:0]     val_r, val_nxt;
  logic [15:0]     cnt_r, cnt_nxt;
  logic [PosW-1:0] pay_end;
  logic [7:0]      len8;
  logic            emit_c;

  assign pay_end = PosW'(len_r) + PosHead;
  assign len8    = 8'(len_r);

  // Advance the frame position and capture fields for one byte
  always_comb begin
    pos_nxt = pos_r;
    wr_nxt  = wr_r;
    len_nxt = len_r;
    sum_nxt = sum_r;
    grp_nxt = grp_r;
    ofs_nxt = ofs_r;
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    emit_c  = 1'b0;
    if (pos_r == PosW'(0) || pos_r == PosW'(1)) begin
      if (rx_byte == sclfp_pkg::SYNC_BYTE) begin
        sum_nxt = (pos_r == PosW'(0)) ? rx_byte : sum_r + rx_byte;
        pos_nxt = pos_r + PosW'(1);
      end else begin
        pos_nxt = '0;
      end
    end else if (pos_r == PosW'(2)) begin
      if (rx_byte == sclfp_pkg::FN_READ || rx_byte == sclfp_pkg::FN_WRITE) begin
        wr_nxt  = (rx_byte == sclfp_pkg::FN_WRITE);
        sum_nxt = sum_r + rx_byte;
        pos_nxt = PosW'(3);
      end else begin
        pos_nxt = '0;
      end
    end else if (pos_r == PosW'(3)) begin
      // Drop a zero or oversize length
      if (rx_byte == 8'd0 || rx_byte > 8'(MAX_PAYLOAD)) begin
        pos_nxt = '0;
      end else begin
        len_nxt = LenW'(rx_byte);
        sum_nxt = sum_r + rx_byte;
        grp_nxt = '0;
        ofs_nxt = '0;
        val_nxt = '0;
        pos_nxt = PosHead;
      end
    end else if (pos_r < pay_end) begin
      // Keep the first four payload bytes, sum them all
      if (pos_r == PosHead) grp_nxt = rx_byte;
      if (pos_r == PosHead + PosW'(1)) ofs_nxt = rx_byte;
      if (pos_r == PosHead + PosW'(2)) val_nxt = {rx_byte, val_r[7:0]};
      if (pos_r == PosHead + PosW'(3)) val_nxt = {val_r[15:8], rx_byte};
      sum_nxt = sum_r + rx_byte;
      pos_nxt = pos_r + PosW'(1);
    end else begin
      // Checksum byte closes the frame
      pos_nxt = '0;
      if (!(checksum_check && rx_byte != sum_r)) begin
        cnt_nxt = cnt_r + 16'd1;
        emit_c  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      wr_r  <= wr_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      grp_r <= grp_nxt;
      ofs_r <= ofs_nxt;
      val_r <= val_nxt;
    end
  end

  assign emit            = emit_c;
  assign res.is_write    = wr_r;
  assign res.group       = grp_r;
  assign res.offset      = ofs_r;
  assign res.value       = val_r;
  assign res.payload_len = len8[3:0];
  assign res.frame_count = cnt_nxt;

endmodule

### rtl/sync_length_checksum_frame_parser.sv
// Channel   Dir  Payload                                        Handshake
// in_bus    in   rx_byte[7:0]                                   valid/ready
// out_bus   out  is_write, group, offset, value, payload_len,   valid/ready
//                frame_count
// cfg       in   cfg_wdata (checksum_check)                     cfg_we, no wait
//
// One byte is taken per cycle unless out_bus stalls; a byte passes the input
// register to the parser, and a frame result goes through the output register.
// The input register and the output register each free up when the next stage
// takes their content, so stalls on out_bus back up into in_bus.ready.
// Synchronous active-low reset clears frame position, frame count and all valids.
module sync_length_checksum_frame_parser #(
  parameter int MAX_PAYLOAD = sclfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sclfp_in_if.sink     in_bus,
  sclfp_out_if.source  out_bus,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  logic               chk_r;
  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               out_valid_r;
  sclfp_pkg::result_t out_res_r;
  logic               adv;
  logic               step;
  logic               emit;
  sclfp_pkg::result_t res;

  // Output slot is free when empty or being drained
  assign adv          = !out_valid_r || out_bus.ready;
  assign step         = s1_valid_r && adv;
  assign in_bus.ready = !s1_valid_r || adv;

  // Hold the checksum enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= 1'b0;
    end else if (cfg_we) begin
      chk_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_byte_r <= in_bus.rx_byte;
    end
  end

  sclfp_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .rx_byte        (s1_byte_r),
    .checksum_check (chk_r),
    .emit           (emit),
    .res            (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.is_write    = out_res_r.is_write;
  assign out_bus.group       = out_res_r.group;
  assign out_bus.offset      = out_res_r.offset;
  assign out_bus.value       = out_res_r.value;
  assign out_bus.payload_len = out_res_r.payload_len;
  assign out_bus.frame_count = out_res_r.frame_count;

endmodule

### tb/testbench.sv
module testbench;

  localparam int MAX_LEN       = sclfp_pkg::MAX_PAYLOAD_DEF;
  localparam int PHASE_BYTES   = 450;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int LIMIT_CYCLES  = 400000;

  // One row of the directed byte stream; typed rows carry the frame expected there
  typedef struct {
    logic [7:0]         rx;
    bit                 typed;
    sclfp_pkg::result_t want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  sclfp_in_if  in_bus ();
  sclfp_out_if out_bus ();

  sync_length_checksum_frame_parser #(
    .MAX_PAYLOAD(MAX_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame tracker state, mirrors the parser after reset
  int unsigned frame_pos = 0;
  logic        wr_flag   = 1'b0;
  logic [7:0]  len_byte  = '0;
  logic [7:0]  sum_acc   = '0;
  logic [7:0]  grp_byte  = '0;
  logic [7:0]  ofs_byte  = '0;
  logic [15:0] val_word  = '0;
  logic [15:0] good_cnt  = '0;
  logic        chk_on    = 1'b0;

  sclfp_pkg::result_t expected_frames[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          hold_req    = 1'b0;

  // Bad header sequences, then two frames whose checksum rows carry typed results
  probe_row_t directed_bytes [30] = '{
    '{8'h00, 1'b0, '0},                  // bad first sync
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{8'h55, 1'b0, '0},                  // bad second sync
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{8'h00, 1'b0, '0},                  // bad function byte
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::FN_READ, 1'b0, '0},
    '{8'h00, 1'b0, '0},                  // zero length
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::FN_READ, 1'b0, '0},
    '{8'(MAX_LEN + 1), 1'b0, '0},        // length above the limit
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::FN_WRITE, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h11, 1'b0, '0},                  // fifth payload byte, summed only
    '{8'h00, 1'b1, '{1'b1, 8'hFF, 8'hFF, 16'hFFFF, 4'd5, 16'd1}},
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::SYNC_BYTE, 1'b0, '0},
    '{sclfp_pkg::FN_READ, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 16'h0000, 4'd1, 16'd2}}
  };

  logic phase_check [3] = '{1'b1, 1'b0, 1'b1};

  // Advance the frame tracker by one byte; got is set when a frame completes
  task automatic parse_byte(input logic [7:0] b, output bit got,
                            output sclfp_pkg::result_t frame);
    int unsigned k;
    got   = 1'b0;
    frame = '0;
    if (frame_pos < 2) begin
      if (b == sclfp_pkg::SYNC_BYTE) begin
        sum_acc   = (frame_pos == 0) ? b : sum_acc + b;
        frame_pos = frame_pos + 1;
      end else begin
        frame_pos = 0;
      end
    end else if (frame_pos == 2) begin
      if (b == sclfp_pkg::FN_READ || b == sclfp_pkg::FN_WRITE) begin
        wr_flag   = (b == sclfp_pkg::FN_WRITE);
        sum_acc   = sum_acc + b;
        frame_pos = 3;
      end else begin
        frame_pos = 0;
      end
    end else if (frame_pos == 3) begin
      if (b == 8'h00 || b > MAX_LEN) begin
        frame_pos = 0;
      end else begin
        len_byte  = b;
        sum_acc   = sum_acc + b;
        grp_byte  = '0;
        ofs_byte  = '0;
        val_word  = '0;
        frame_pos = 4;
      end
    end else if (frame_pos < sclfp_pkg::HEAD_LEN + len_byte) begin
      k = frame_pos - sclfp_pkg::HEAD_LEN;
      case (k)
        0: grp_byte = b;
        1: ofs_byte = b;
        2: val_word[15:8] = b;
        3: val_word[7:0] = b;
        default: ;
      endcase
      sum_acc   = sum_acc + b;
      frame_pos = frame_pos + 1;
    end else begin
      // Checksum byte closes the frame
      frame_pos = 0;
      if (!(chk_on && b != sum_acc)) begin
        good_cnt = good_cnt + 1;
        got      = 1'b1;
        frame    = '{wr_flag, grp_byte, ofs_byte, val_word, len_byte[3:0], good_cnt};
      end
    end
  endtask

  // Mostly no idling, sometimes a few cycles, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte, hold it until the transfer, then idle for a random gap unless steady
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input sclfp_pkg::result_t want, input bit steady);
    int                 gap;
    bit                 got;
    sclfp_pkg::result_t frame;
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    parse_byte(b, got, frame);
    if (typed) expected_frames.push_back(want);
    else if (got) expected_frames.push_back(frame);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Build one random sequence: complete frame (checksum sometimes wrong), cut frame, broken header or noise
  task automatic send_random_sequence(output int counted);
    logic [7:0] seq[$];
    logic [7:0] fn;
    logic [7:0] sum;
    logic [7:0] b;
    int         kind;
    int         len;
    int         cut;
    bit         steady;
    steady = ($urandom_range(0, 3) == 0);
    kind   = $urandom_range(0, 99);
    fn     = $urandom_range(0, 1) ? sclfp_pkg::FN_WRITE : sclfp_pkg::FN_READ;
    if (kind < 80) begin
      len = $urandom_range(1, MAX_LEN);
      seq = '{sclfp_pkg::SYNC_BYTE, sclfp_pkg::SYNC_BYTE, fn, 8'(len)};
      repeat (len) seq.push_back(8'($urandom_range(0, 255)));
      if (kind < 70) begin
        sum = '0;
        foreach (seq[i]) sum = sum + seq[i];
        seq.push_back(($urandom_range(0, 3) != 0) ? sum : 8'($urandom_range(0, 255)));
      end else begin
        // Cut the frame short so the next bytes land inside it
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end else if (kind < 90) begin
      if ($urandom_range(0, 1)) begin
        do b = 8'($urandom_range(0, 255));
        while (b == sclfp_pkg::FN_READ || b == sclfp_pkg::FN_WRITE);
        seq = '{sclfp_pkg::SYNC_BYTE, sclfp_pkg::SYNC_BYTE, b};
      end else begin
        b   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(MAX_LEN + 1, 255));
        seq = '{sclfp_pkg::SYNC_BYTE, sclfp_pkg::SYNC_BYTE, fn, b};
      end
    end else begin
      repeat ($urandom_range(1, 6))
        seq.push_back(($urandom_range(0, 3) == 0) ? sclfp_pkg::SYNC_BYTE
                                                  : 8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) send_byte(seq[i], 1'b0, '0, steady);
    counted = (kind < 80) ? seq.size() : 0;
  endtask

  // Drop valid, wait for every frame to come out, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_check_enable(input logic en);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we    <= 1'b0;
    chk_on = en;
  endtask

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin : drive_ready
    int run;
    int stall;
    int quiet_runs;
    quiet_runs = 0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end
      run = $urandom_range(1, 12);
      @(negedge clk);
      out_bus.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (quiet_runs == 0 && $urandom_range(0, 9) == 0) quiet_runs = 30;
      if (quiet_runs > 0) begin
        quiet_runs--;
        stall = 0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Compare each frame transfer with the oldest expected frame
  always @(posedge clk) begin : check_frames
    sclfp_pkg::result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: expected no frame, got frame_count %0d", $time,
                 out_bus.frame_count);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (out_bus.is_write !== want.is_write) begin
          $display("%0t: is_write expected %0d got %0d", $time, want.is_write,
                   out_bus.is_write);
          mismatches++;
        end
        if (out_bus.group !== want.group) begin
          $display("%0t: group expected %02h got %02h", $time, want.group, out_bus.group);
          mismatches++;
        end
        if (out_bus.offset !== want.offset) begin
          $display("%0t: offset expected %02h got %02h", $time, want.offset, out_bus.offset);
          mismatches++;
        end
        if (out_bus.value !== want.value) begin
          $display("%0t: value expected %04h got %04h", $time, want.value, out_bus.value);
          mismatches++;
        end
        if (out_bus.payload_len !== want.payload_len) begin
          $display("%0t: payload_len expected %0d got %0d", $time, want.payload_len,
                   out_bus.payload_len);
          mismatches++;
        end
        if (out_bus.frame_count !== want.frame_count) begin
          $display("%0t: frame_count expected %0d got %0d", $time, want.frame_count,
                   out_bus.frame_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : run_stimulus
    int sent;
    int counted;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed stream with the checksum compare off, as after reset
    foreach (directed_bytes[i])
      send_byte(directed_bytes[i].rx, directed_bytes[i].typed, directed_bytes[i].want, 1'b0);
    settle();

    // Random phases, each under its own checksum setting
    foreach (phase_check[p]) begin
      write_check_enable(phase_check[p]);
      if (p == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_random_sequence(counted);
        sent += counted;
      end
      settle();
    end

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
